/* sv/lapyu_pkg.sv */
// Package for the lever arm pose and yaw unwrap block.
// Holds angle constants, register codes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package lapyu_pkg;
    localparam int TAB_LEN = 24;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam logic signed [25:0] DEG180 = 26'sd11796480;
    localparam logic signed [25:0] DEG90 = 26'sd5898240;
    localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;
    localparam logic signed [20:0] RST_DX = 21'sd721;
    localparam logic signed [20:0] RST_DY = 21'sd1526;
    localparam logic signed [20:0] RST_L = 21'sd15870;
    localparam logic [1:0] REG_DX = 2'd0;
    localparam logic [1:0] REG_DY = 2'd1;
    localparam logic [1:0] REG_L = 2'd2;

    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* sv/lapyu_cordic.sv */
// Shared CORDIC engine: vectoring mode for atan2 and rotation mode for cos/sin.
// One micro-rotation per cycle. Depends on lapyu_pkg.
`default_nettype none
module lapyu_cordic #(
    parameter int ITERS = lapyu_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_vec,
    input  wire logic signed [34:0] i_x,
    input  wire logic signed [34:0] i_y,
    input  wire logic signed [25:0] i_z,
    output logic                    o_done,
    output logic signed [34:0]      o_x,
    output logic signed [34:0]      o_y,
    output logic signed [25:0]      o_z
);
    import lapyu_pkg::*;

    localparam int N = (ITERS < TAB_LEN) ? ITERS : TAB_LEN;

    logic             r_busy;
    logic [4:0]       r_i;
    logic             r_vec;
    logic signed [34:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic             dir;
    logic signed [25:0] at;

    assign at = $signed({4'd0, atan_tab(r_i)});
    assign dir = r_vec ? ~r_y[34] : ~r_z[25];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i <= '0;
                r_vec <= i_vec;
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end else if (r_busy) begin
                if (dir ^ ~r_vec) begin
                    r_x <= r_x + (r_y >>> r_i);
                    r_y <= r_y - (r_x >>> r_i);
                end else begin
                    r_x <= r_x - (r_y >>> r_i);
                    r_y <= r_y + (r_x >>> r_i);
                end
                r_z <= (dir ^ ~r_vec) ? r_z + at : r_z - at;
                if (r_i == 5'(N - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

/* sv/lever_arm_pose_and_yaw_unwrap.sv */
// Top level of the lever arm pose and yaw unwrap block.
// Depends on lapyu_pkg and lapyu_cordic.
//
// Each sample runs a sequence of multiplies for the yaw vector, then a
// vectoring CORDIC for yaw, then a rotation CORDIC for cos/sin on the same
// shared engine, then a second sequence of multiplies; all multiplies use one
// shared 32x32 multiplier. A new input beat is taken only in S_IDLE, so a
// sample leaves its final step before the next is accepted. A finished beat
// waits in the output register while i_out_stall is high; the next sample is
// computed meanwhile and waits in its final step until the output register is
// free.
`default_nettype none
module lever_arm_pose_and_yaw_unwrap #(
    parameter int CORDIC_ITERS = lapyu_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_robot_x,
    output logic signed [31:0]      o_robot_y,
    output logic signed [24:0]      o_yaw_deg,
    output logic signed [47:0]      o_yaw_unwrapped,
    output logic signed [15:0]      o_turn_count
);
    import lapyu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AB, S_VEC, S_VWAIT, S_ROT, S_RWAIT, S_MUL, S_FIN
    } t_state;

    t_state r_state;
    logic signed [20:0] r_dx, r_dy, r_l;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0] r_px, r_py;
    logic signed [24:0] r_last, r_yaw;
    logic signed [15:0] r_turns;
    logic [3:0] r_k;
    logic signed [33:0] r_a, r_b;
    logic signed [31:0] r_c, r_s;
    logic signed [53:0] r_sx, r_sy;
    logic r_neg;
    logic fin_go;

    logic c_start, c_vec, c_done;
    logic signed [34:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [25:0] c_zi, c_zo;

    lapyu_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_vec(c_vec),
        .i_x(c_xi), .i_y(c_yi), .i_z(c_zi), .o_done(c_done),
        .o_x(c_xo), .o_y(c_yo), .o_z(c_zo)
    );

    // Shared multiplier: operands picked by step counter.
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_k)
            4'd0: begin m_a = 32'(r_qx); m_b = 32'(r_qy); end
            4'd1: begin m_a = 32'(r_qw); m_b = 32'(r_qz); end
            4'd2: begin m_a = 32'(r_qy); m_b = 32'(r_qy); end
            4'd3: begin m_a = 32'(r_qz); m_b = 32'(r_qz); end
            4'd4: begin m_a = 32'(r_dx); m_b = r_c; end
            4'd5: begin m_a = 32'(r_dy); m_b = r_s; end
            4'd6: begin m_a = 32'(r_l);  m_b = r_s; end
            4'd7: begin m_a = 32'(r_dx); m_b = r_s; end
            4'd8: begin m_a = 32'(r_dy); m_b = r_c; end
            4'd9: begin m_a = 32'(r_l);  m_b = r_c; end
            default: ;
        endcase
        m_p = m_a * m_b;
    end

    logic signed [25:0] z_cl, t_in;
    logic signed [25:0] diff;
    logic signed [53:0] rnd_x, rnd_y;
    logic signed [34:0] rx, ry;
    logic signed [15:0] n_turns;
    logic signed [31:0] sx32, sy32;
    always_comb begin
        z_cl = c_zo;
        if (c_zo > DEG180) z_cl = DEG180;
        if (c_zo < -DEG180) z_cl = -DEG180;
        t_in = 26'(r_yaw);
        if (26'(r_yaw) > DEG90) t_in = 26'(r_yaw) - DEG180;
        else if (26'(r_yaw) < -DEG90) t_in = 26'(r_yaw) + DEG180;
        c_vec = (r_state == S_VEC);
        c_start = (r_state == S_VEC) || (r_state == S_ROT);
        c_xi = (r_state == S_VEC) ? 35'(r_b[33] ? -r_b : r_b) : 35'(KINV_Q30);
        c_yi = (r_state == S_VEC) ? 35'(r_b[33] ? -r_a : r_a) : '0;
        c_zi = (r_state == S_VEC) ? (r_b[33] ? (r_a[33] ? -DEG180 : DEG180) : '0) : t_in;
        rnd_x = (r_sx + 54'sd536870912) >>> 30;
        rnd_y = (r_sy + 54'sd536870912) >>> 30;
        rx = 35'(r_px) + 35'(r_dx) + 35'(rnd_x);
        ry = 35'(r_py) + 35'(r_dy) + 35'(r_l) + 35'(rnd_y);
        sx32 = (rx > 35'sd2147483647) ? 32'h7fffffff :
               (rx < -35'sd2147483648) ? 32'h80000000 : rx[31:0];
        sy32 = (ry > 35'sd2147483647) ? 32'h7fffffff :
               (ry < -35'sd2147483648) ? 32'h80000000 : ry[31:0];
        diff = 26'(r_yaw) - 26'(r_last);
        n_turns = r_turns;
        if (diff > DEG180) begin
            if (r_turns != -16'sd32768) n_turns = r_turns - 16'sd1;
        end else if (diff < -DEG180) begin
            if (r_turns != 16'sd32767) n_turns = r_turns + 16'sd1;
        end
    end

    assign pready = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign fin_go = (r_state == S_FIN) && (!o_out_valid || !i_out_stall);
    always_comb begin
        unique case (paddr[3:2])
            REG_DX: prdata = 32'(r_dx);
            REG_DY: prdata = 32'(r_dy);
            REG_L: prdata = 32'(r_l);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dx <= RST_DX;
            r_dy <= RST_DY;
            r_l <= RST_L;
            r_last <= '0;
            r_turns <= '0;
            o_out_valid <= 1'b0;
            r_k <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_DX: r_dx <= pwdata[20:0];
                    REG_DY: r_dy <= pwdata[20:0];
                    REG_L: r_l <= pwdata[20:0];
                    default: ;
                endcase
            end
            if (fin_go) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_qw <= i_quat_w; r_qx <= i_quat_x;
                    r_qy <= i_quat_y; r_qz <= i_quat_z;
                    r_px <= i_pos_x; r_py <= i_pos_y;
                    r_k <= '0;
                    r_a <= '0;
                    r_b <= 34'sd1073741824;
                    r_state <= S_AB;
                end
                S_AB: begin
                    if (r_k < 4'd2) r_a <= r_a + 34'(m_p <<< 1);
                    else r_b <= r_b - 34'(m_p <<< 1);
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd3) r_state <= S_VEC;
                end
                S_VEC: begin
                    r_neg <= 1'b0;
                    r_state <= S_VWAIT;
                end
                S_VWAIT: if (c_done) begin
                    r_yaw <= (r_a == 0 && r_b == 0) ? '0 : 25'(z_cl);
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_neg <= (26'(r_yaw) > DEG90) || (26'(r_yaw) < -DEG90);
                    r_state <= S_RWAIT;
                end
                S_RWAIT: if (c_done) begin
                    r_c <= r_neg ? -c_xo[31:0] : c_xo[31:0];
                    r_s <= r_neg ? -c_yo[31:0] : c_yo[31:0];
                    r_sx <= '0; r_sy <= '0;
                    r_k <= 4'd4;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    unique case (r_k)
                        4'd4: r_sx <= r_sx - 54'(m_p);
                        4'd5, 4'd6: r_sx <= r_sx + 54'(m_p);
                        default: r_sy <= r_sy - 54'(m_p);
                    endcase
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd9) r_state <= S_FIN;
                end
                S_FIN: if (fin_go) begin
                    o_robot_x <= sx32;
                    o_robot_y <= sy32;
                    o_yaw_deg <= r_yaw;
                    o_turn_count <= n_turns;
                    o_yaw_unwrapped <= 48'(r_yaw) + 48'(n_turns) * 48'sd23592960;
                    r_turns <= n_turns;
                    r_last <= r_yaw;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> (o_out_valid && $stable(o_robot_x) &&
        $stable(o_yaw_deg) && $stable(o_turn_count)))
        else $error("stalled result beat changed");
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> (r_turns - $past(r_turns) <= 16'sd1 &&
        $past(r_turns) - r_turns <= 16'sd1)) else $error("turn count jumped");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (26'(o_yaw_deg) <= DEG180 && 26'(o_yaw_deg) >= -DEG180))
        else $error("yaw out of range");
`endif
endmodule
`default_nettype wire
